// ----- src/sco_pkg.sv -----
package sco_pkg;

    // Coordinate and radius widths
    localparam int CW    = 16;
    localparam int RW    = CW - 1;

    // Internal arithmetic widths
    localparam int DW     = CW + 1;          // coordinate difference, signed
    localparam int SQ_W   = 2 * DW - 2;      // one squared difference
    localparam int XP_W   = 2 * DW - 1;      // one cross term, signed
    localparam int SUM_W  = 2 * DW;          // sum of three squares
    localparam int PJ_W   = SUM_W + 1;       // projection, signed
    localparam int R2_W   = 2 * CW;          // squared radius sum
    localparam int HALF_W = SUM_W / 2;       // split point for wide products
    localparam int PP_W   = SUM_W + HALF_W;  // partial product
    localparam int WIDE_W = 2 * SUM_W;       // full product

    // Input word layout, lowest bits first
    localparam int OFF_SX = 0;
    localparam int OFF_SY = CW;
    localparam int OFF_SZ = 2 * CW;
    localparam int OFF_SR = 3 * CW;
    localparam int OFF_BX = 3 * CW + RW;
    localparam int OFF_BY = 4 * CW + RW;
    localparam int OFF_BZ = 5 * CW + RW;
    localparam int OFF_TX = 6 * CW + RW;
    localparam int OFF_TY = 7 * CW + RW;
    localparam int OFF_TZ = 8 * CW + RW;
    localparam int OFF_CR = 9 * CW + RW;
    localparam int IN_RAW = 9 * CW + 2 * RW;
    localparam int IN_W   = ((IN_RAW + 7) / 8) * 8;
    localparam int OUT_W  = 8;

    localparam int NUM_STAGES = 6;

endpackage

// ----- src/sphere_capsule_overlap_test.sv -----
// Sphere versus capsule overlap test, six-stage pipeline.
// An accepted input word passes through the registers of stages 1 to 6 in
// order. Throughput: one word per cycle while the output is not stalled; each
// stage holds its word only while the stage after it is full and stalled, so
// bubbles are squeezed out on a stall.
// Reset (rst_n low, asynchronous) clears the stage valid bits only.
module sphere_capsule_overlap_test (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // sphere_x, sphere_y, sphere_z, sphere_radius, base_x, base_y, base_z,
    // tip_x, tip_y, tip_z, capsule_radius, zero pad
    input  logic [sco_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // overlap, zero pad
    output logic [sco_pkg::OUT_W-1:0]  m_axis_tdata
);
    import sco_pkg::*;

    // Stage handshake
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] stg_rdy;

    // Input fields
    logic signed [CW-1:0] pos_p [3];
    logic signed [CW-1:0] pos_a [3];
    logic signed [CW-1:0] pos_b [3];
    logic [RW-1:0]        sphere_radius;
    logic [RW-1:0]        capsule_radius;

    // Stage 1: differences and radius sum
    logic signed [DW-1:0] s1_ab_reg [3];
    logic signed [DW-1:0] s1_ap_reg [3];
    logic signed [DW-1:0] s1_bp_reg [3];
    logic signed [DW-1:0] s1_ab_next [3];
    logic signed [DW-1:0] s1_ap_next [3];
    logic signed [DW-1:0] s1_bp_next [3];
    logic [CW-1:0]        s1_r_reg;
    logic [CW-1:0]        s1_r_next;

    // Stage 2: per-axis products
    logic signed [2*DW-1:0] sq_ab [3];
    logic signed [2*DW-1:0] sq_ap [3];
    logic signed [2*DW-1:0] sq_bp [3];
    logic signed [2*DW-1:0] xp_dot [3];
    logic [SQ_W-1:0]        s2_ab2_reg [3];
    logic [SQ_W-1:0]        s2_ap2_reg [3];
    logic [SQ_W-1:0]        s2_bp2_reg [3];
    logic signed [XP_W-1:0] s2_dot_reg [3];
    logic [R2_W-1:0]        s2_r2_reg;
    logic [SQ_W-1:0]        s2_ab2_next [3];
    logic [SQ_W-1:0]        s2_ap2_next [3];
    logic [SQ_W-1:0]        s2_bp2_next [3];
    logic signed [XP_W-1:0] s2_dot_next [3];
    logic [R2_W-1:0]        s2_r2_next;

    // Stage 3: sums over axes
    logic [SUM_W-1:0]        s3_l_reg, s3_l_next;
    logic [SUM_W-1:0]        s3_ap2_reg, s3_ap2_next;
    logic [SUM_W-1:0]        s3_bp2_reg, s3_bp2_next;
    logic signed [PJ_W-1:0]  s3_proj_reg, s3_proj_next;
    logic [R2_W-1:0]         s3_r2_reg, s3_r2_next;

    // Stage 4: region select, end-point tests, partial products
    logic             s4_mid_reg, s4_mid_next;
    logic             s4_side_hit_reg, s4_side_hit_next;
    logic [PP_W-1:0]  s4_ap2l_lo_reg, s4_ap2l_lo_next;
    logic [PP_W-1:0]  s4_ap2l_hi_reg, s4_ap2l_hi_next;
    logic [PP_W-1:0]  s4_r2l_lo_reg, s4_r2l_lo_next;
    logic [PP_W-1:0]  s4_r2l_hi_reg, s4_r2l_hi_next;
    logic [PP_W-1:0]  s4_pj2_lo_reg, s4_pj2_lo_next;
    logic [PP_W-1:0]  s4_pj2_hi_reg, s4_pj2_hi_next;
    logic             proj_le0;
    logic             proj_geL;
    logic [SUM_W-1:0] pj_mag;
    logic [SUM_W-1:0] r2_ext;

    // Stage 5: full products
    logic              s5_mid_reg, s5_mid_next;
    logic              s5_side_hit_reg, s5_side_hit_next;
    logic [WIDE_W-1:0] s5_lhs_reg, s5_lhs_next;
    logic [WIDE_W-1:0] s5_r2l_reg, s5_r2l_next;
    logic [WIDE_W-1:0] s5_pj2_reg, s5_pj2_next;

    // Stage 6: result
    logic            overlap_reg, overlap_next;
    logic [WIDE_W:0] rhs_sum;

    // Ready chain: a stage takes a word when empty or when it is moving on
    always_comb
    begin
        stg_rdy[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_axis_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            stg_rdy[k] = !vld_reg[k] || stg_rdy[k+1];
        end
        vld_next[0] = s_axis_tvalid;
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            vld_next[k] = vld_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NUM_STAGES; k++)
            begin
                if (stg_rdy[k])
                begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    assign s_axis_tready = stg_rdy[0];
    assign m_axis_tvalid = vld_reg[NUM_STAGES-1];
    assign m_axis_tdata  = {{(OUT_W-1){1'b0}}, overlap_reg};

    // Field unpack
    always_comb
    begin
        pos_p[0]       = s_axis_tdata[OFF_SX +: CW];
        pos_p[1]       = s_axis_tdata[OFF_SY +: CW];
        pos_p[2]       = s_axis_tdata[OFF_SZ +: CW];
        sphere_radius  = s_axis_tdata[OFF_SR +: RW];
        pos_a[0]       = s_axis_tdata[OFF_BX +: CW];
        pos_a[1]       = s_axis_tdata[OFF_BY +: CW];
        pos_a[2]       = s_axis_tdata[OFF_BZ +: CW];
        pos_b[0]       = s_axis_tdata[OFF_TX +: CW];
        pos_b[1]       = s_axis_tdata[OFF_TY +: CW];
        pos_b[2]       = s_axis_tdata[OFF_TZ +: CW];
        capsule_radius = s_axis_tdata[OFF_CR +: RW];
    end

    // Stage 1: AB = B - A, AP = P - A, BP = P - B, R = rs + rc
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s1_ab_next[i] = DW'(pos_b[i]) - DW'(pos_a[i]);
            s1_ap_next[i] = DW'(pos_p[i]) - DW'(pos_a[i]);
            s1_bp_next[i] = DW'(pos_p[i]) - DW'(pos_b[i]);
        end
        s1_r_next = CW'(sphere_radius) + CW'(capsule_radius);
    end

    // Stage 2: squares, cross terms, R^2
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_ab[i]  = s1_ab_reg[i] * s1_ab_reg[i];
            sq_ap[i]  = s1_ap_reg[i] * s1_ap_reg[i];
            sq_bp[i]  = s1_bp_reg[i] * s1_bp_reg[i];
            xp_dot[i] = s1_ap_reg[i] * s1_ab_reg[i];
            s2_ab2_next[i] = sq_ab[i][SQ_W-1:0];
            s2_ap2_next[i] = sq_ap[i][SQ_W-1:0];
            s2_bp2_next[i] = sq_bp[i][SQ_W-1:0];
            s2_dot_next[i] = xp_dot[i][XP_W-1:0];
        end
        s2_r2_next = s1_r_reg * s1_r_reg;
    end

    // Stage 3: L, |AP|^2, |BP|^2, proj
    always_comb
    begin
        s3_l_next    = SUM_W'(s2_ab2_reg[0]) + SUM_W'(s2_ab2_reg[1])
                     + SUM_W'(s2_ab2_reg[2]);
        s3_ap2_next  = SUM_W'(s2_ap2_reg[0]) + SUM_W'(s2_ap2_reg[1])
                     + SUM_W'(s2_ap2_reg[2]);
        s3_bp2_next  = SUM_W'(s2_bp2_reg[0]) + SUM_W'(s2_bp2_reg[1])
                     + SUM_W'(s2_bp2_reg[2]);
        s3_proj_next = PJ_W'(s2_dot_reg[0]) + PJ_W'(s2_dot_reg[1])
                     + PJ_W'(s2_dot_reg[2]);
        s3_r2_next   = s2_r2_reg;
    end

    // Stage 4: pick end point A, end point B or the interior; split products
    always_comb
    begin
        // proj is known positive and below 2^SUM_W whenever it is used here
        pj_mag   = s3_proj_reg[SUM_W-1:0];
        r2_ext   = SUM_W'(s3_r2_reg);
        proj_le0 = s3_proj_reg[PJ_W-1] || (s3_proj_reg == '0);
        proj_geL = pj_mag >= s3_l_reg;

        s4_mid_next = !proj_le0 && !proj_geL;
        if (proj_le0)
        begin
            s4_side_hit_next = s3_ap2_reg <= r2_ext;
        end
        else
        begin
            s4_side_hit_next = s3_bp2_reg <= r2_ext;
        end

        s4_ap2l_lo_next = PP_W'(s3_ap2_reg) * PP_W'(s3_l_reg[HALF_W-1:0]);
        s4_ap2l_hi_next = PP_W'(s3_ap2_reg) * PP_W'(s3_l_reg[SUM_W-1:HALF_W]);
        s4_r2l_lo_next  = PP_W'(r2_ext) * PP_W'(s3_l_reg[HALF_W-1:0]);
        s4_r2l_hi_next  = PP_W'(r2_ext) * PP_W'(s3_l_reg[SUM_W-1:HALF_W]);
        s4_pj2_lo_next  = PP_W'(pj_mag) * PP_W'(pj_mag[HALF_W-1:0]);
        s4_pj2_hi_next  = PP_W'(pj_mag) * PP_W'(pj_mag[SUM_W-1:HALF_W]);
    end

    // Stage 5: join partial products
    always_comb
    begin
        s5_mid_next      = s4_mid_reg;
        s5_side_hit_next = s4_side_hit_reg;
        s5_lhs_next = (WIDE_W'(s4_ap2l_hi_reg) << HALF_W) + WIDE_W'(s4_ap2l_lo_reg);
        s5_r2l_next = (WIDE_W'(s4_r2l_hi_reg) << HALF_W) + WIDE_W'(s4_r2l_lo_reg);
        s5_pj2_next = (WIDE_W'(s4_pj2_hi_reg) << HALF_W) + WIDE_W'(s4_pj2_lo_reg);
    end

    // Stage 6: |AP|^2*L <= R^2*L + proj^2 for the interior case
    always_comb
    begin
        rhs_sum = (WIDE_W+1)'(s5_r2l_reg) + (WIDE_W+1)'(s5_pj2_reg);
        if (s5_mid_reg)
        begin
            overlap_next = (WIDE_W+1)'(s5_lhs_reg) <= rhs_sum;
        end
        else
        begin
            overlap_next = s5_side_hit_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (stg_rdy[0] && vld_next[0])
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_ab_reg[i] <= s1_ab_next[i];
                s1_ap_reg[i] <= s1_ap_next[i];
                s1_bp_reg[i] <= s1_bp_next[i];
            end
            s1_r_reg <= s1_r_next;
        end
        if (stg_rdy[1] && vld_next[1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                s2_ab2_reg[i] <= s2_ab2_next[i];
                s2_ap2_reg[i] <= s2_ap2_next[i];
                s2_bp2_reg[i] <= s2_bp2_next[i];
                s2_dot_reg[i] <= s2_dot_next[i];
            end
            s2_r2_reg <= s2_r2_next;
        end
        if (stg_rdy[2] && vld_next[2])
        begin
            s3_l_reg    <= s3_l_next;
            s3_ap2_reg  <= s3_ap2_next;
            s3_bp2_reg  <= s3_bp2_next;
            s3_proj_reg <= s3_proj_next;
            s3_r2_reg   <= s3_r2_next;
        end
        if (stg_rdy[3] && vld_next[3])
        begin
            s4_mid_reg      <= s4_mid_next;
            s4_side_hit_reg <= s4_side_hit_next;
            s4_ap2l_lo_reg  <= s4_ap2l_lo_next;
            s4_ap2l_hi_reg  <= s4_ap2l_hi_next;
            s4_r2l_lo_reg   <= s4_r2l_lo_next;
            s4_r2l_hi_reg   <= s4_r2l_hi_next;
            s4_pj2_lo_reg   <= s4_pj2_lo_next;
            s4_pj2_hi_reg   <= s4_pj2_hi_next;
        end
        if (stg_rdy[4] && vld_next[4])
        begin
            s5_mid_reg      <= s5_mid_next;
            s5_side_hit_reg <= s5_side_hit_next;
            s5_lhs_reg      <= s5_lhs_next;
            s5_r2l_reg      <= s5_r2l_next;
            s5_pj2_reg      <= s5_pj2_next;
        end
        if (stg_rdy[5] && vld_next[5])
        begin
            overlap_reg <= overlap_next;
        end
    end

endmodule
